// ===== design/grid_line_of_sight_dda_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid line-of-sight unit
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_DDA_UNIT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_DDA_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GLOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glos: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glos: next-cycle check failed");

`endif

// ===== design/glos_pkg.sv =====
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types, constants and helpers of the grid line-of-sight unit.
// ----------------------------------------------------------------------------
package glos_pkg;

    localparam int MAP_SIZE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 8;

    localparam int POS_W      = 14;
    localparam int CELL_W     = 6;
    localparam int DIR_W      = 16;
    localparam int DIR_ONE    = 16384;
    localparam int SUM_W      = 2 * POS_W + 1;
    localparam int SQ_W       = 23;
    localparam int RAD_W      = 2 * SQ_W;
    localparam int LEN_SHIFT  = 16;
    localparam int DIR_SHIFT  = 22;
    localparam int NUM_W      = POS_W + DIR_SHIFT + 1;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PREP, ST_MUL, ST_SUM, ST_SQRT,
        ST_DCOL_LD, ST_DCOL, ST_DROW_LD, ST_DROW,
        ST_WALK_LD, ST_STEP, ST_TEST, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_PREP, OP_MUL, OP_SUM, OP_SQRT,
        OP_DCOL_LD, OP_DROW_LD, OP_DIV, OP_WALK_LD, OP_STEP, OP_TEST
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
        logic   map_we;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic same_cell;
        logic cnt_zero;
        logic hit;
        logic blocked;
    } t_dp_stat;

    // saturate a quotient to one and apply the sign
    function automatic logic signed [DIR_W-1:0] unit_dir(input logic [NUM_W-1:0] q,
                                                         input logic neg);
        logic [DIR_W-1:0] m;
        m = (q > NUM_W'(DIR_ONE)) ? DIR_W'(DIR_ONE) : q[DIR_W-1:0];
        return $signed(neg ? (~m + 1'b1) : m);
    endfunction

endpackage

// ===== design/glos_ram.sv =====
// ----------------------------------------------------------------------------
// glos_ram
// Single-port RAM, one access per cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/glos_dp.sv =====
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: query setup, bit-serial square root, shared serial divider,
// incremental cross-product DDA walk, wall map and result register.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_dda_unit_assert.svh"

module glos_dp #(
    parameter int MAP_SIZE  = glos_pkg::MAP_SIZE_DEF,
    parameter int FRAC_BITS = glos_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  glos_pkg::t_dp_cmd                  i_cmd,
    output glos_pkg::t_dp_stat                 o_stat,
    input  logic [glos_pkg::IN_TDATA_W-1:0]    i_tdata,
    output logic [glos_pkg::OUT_TDATA_W-1:0]   o_tdata
);
    import glos_pkg::*;

    localparam int CW         = $clog2(MAP_SIZE);
    localparam int AW         = 2 * CW;
    localparam int CRD_W      = (FRAC_BITS < POS_W) ? POS_W - FRAC_BITS : 1;
    localparam int CX_W       = ((CRD_W > CW) ? CRD_W : CW) + 2;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int WALK_LIMIT = 4 * MAP_SIZE + 4;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam int P_W        = FRAC_BITS + POS_W + STEP_W + 1;
    localparam int CNT_MAX    = (WALK_LIMIT > NUM_W) ? WALK_LIMIT : NUM_W;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);

    localparam logic [T_W-1:0]         ONE_T   = T_W'(1) << FRAC_BITS;
    localparam logic signed [CX_W-1:0] MAP_S   = CX_W'(MAP_SIZE);
    localparam logic signed [CX_W-1:0] CX_PLUS = CX_W'(1);
    localparam logic signed [CX_W-1:0] CX_MIN  = '1;

    // input fields
    logic [CELL_W-1:0] in_col, in_row;
    logic              in_wall;
    assign in_col  = i_tdata[5:0];
    assign in_row  = i_tdata[11:6];
    assign in_wall = i_tdata[12];

    logic [POS_W-1:0] r_mcol, r_mrow, r_pcol, r_prow;
    logic             r_atk, r_fail, r_started;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mcol    <= i_tdata[26:13];
            r_mrow    <= i_tdata[40:27];
            r_pcol    <= i_tdata[54:41];
            r_prow    <= i_tdata[68:55];
            r_atk     <= i_tdata[69];
            r_fail    <= i_tdata[70];
            r_started <= i_tdata[71];
        end
    end

    // setup terms
    logic [CRD_W-1:0] mc, mr, pc, pr;
    logic [POS_W-1:0] mbase_c, mbase_r, frac_c, frac_r;
    logic [POS_W:0]   dx, dy, ndx, ndy;
    assign mc      = CRD_W'(r_mcol >> FRAC_BITS);
    assign mr      = CRD_W'(r_mrow >> FRAC_BITS);
    assign pc      = CRD_W'(r_pcol >> FRAC_BITS);
    assign pr      = CRD_W'(r_prow >> FRAC_BITS);
    assign mbase_c = (r_mcol >> FRAC_BITS) << FRAC_BITS;
    assign mbase_r = (r_mrow >> FRAC_BITS) << FRAC_BITS;
    assign frac_c  = r_mcol - mbase_c;
    assign frac_r  = r_mrow - mbase_r;
    assign dx      = {1'b0, r_pcol} - {1'b0, mbase_c};
    assign dy      = {1'b0, r_prow} - {1'b0, mbase_r};
    assign ndx     = ~dx + 1'b1;
    assign ndy     = ~dy + 1'b1;

    logic [POS_W-1:0]       r_ax, r_ay;
    logic                   r_negx, r_negy;
    logic [T_W-1:0]         r_tx0, r_ty0;
    logic [CRD_W-1:0]       r_pc, r_pr;
    logic                   r_same;
    logic [2*POS_W-1:0]     r_sqx, r_sqy;
    logic [P_W-1:0]         r_p, r_q;
    logic [RAD_W-1:0]       r_rad;
    logic [SQ_W-1:0]        r_root;
    logic [SQ_W:0]          r_srem;
    logic [NUM_W-1:0]       r_num;
    logic [SQ_W:0]          r_drem;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic                   r_vis;
    logic signed [DIR_W-1:0] r_dcol, r_drow;
    logic [AW-1:0]          r_clr;

    // square root digit
    logic [SQ_W+2:0] sq_sh, sq_trial;
    logic            sq_ge;
    assign sq_sh    = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    // division digit
    logic [SQ_W+1:0] dv_sh;
    logic            dv_ge;
    assign dv_sh = {r_drem, r_num[NUM_W-1]};
    assign dv_ge = dv_sh >= {2'b00, r_root};

    // walk step
    logic                   xstep;
    logic signed [CX_W-1:0] step_cx, step_cy;
    assign xstep   = r_p < r_q;
    assign step_cx = xstep ? r_cx + (r_negx ? CX_MIN : CX_PLUS) : r_cx;
    assign step_cy = xstep ? r_cy : r_cy + (r_negy ? CX_MIN : CX_PLUS);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_PREP: begin
                r_ax   <= dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
                r_ay   <= dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
                r_negx <= dx[POS_W];
                r_negy <= dy[POS_W];
                r_tx0  <= dx[POS_W] ? T_W'(frac_c) : ONE_T - T_W'(frac_c);
                r_ty0  <= dy[POS_W] ? T_W'(frac_r) : ONE_T - T_W'(frac_r);
                r_pc   <= pc;
                r_pr   <= pr;
                r_same <= (mc == pc) && (mr == pr);
                r_cx   <= CX_W'(mc);
                r_cy   <= CX_W'(mr);
                r_vis  <= (mc == pc) && (mr == pr);
                r_dcol <= '0;
                r_drow <= '0;
            end
            OP_MUL: begin
                r_sqx <= (2*POS_W)'(r_ax) * (2*POS_W)'(r_ax);
                r_sqy <= (2*POS_W)'(r_ay) * (2*POS_W)'(r_ay);
                r_p   <= P_W'(r_tx0) * P_W'(r_ay);
                r_q   <= P_W'(r_ty0) * P_W'(r_ax);
            end
            OP_SUM: begin
                r_rad  <= RAD_W'(SUM_W'(r_sqx) + SUM_W'(r_sqy)) << LEN_SHIFT;
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= CNT_W'(SQ_W - 1);
            end
            OP_SQRT: begin
                r_rad  <= r_rad << 2;
                r_srem <= sq_ge ? (SQ_W+1)'(sq_sh - sq_trial) : sq_sh[SQ_W:0];
                r_root <= {r_root[SQ_W-2:0], sq_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            OP_DCOL_LD: begin
                r_num  <= (NUM_W'(r_ax) << DIR_SHIFT) + NUM_W'(r_root >> 1);
                r_drem <= '0;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end
            OP_DIV: begin
                r_drem <= dv_ge ? (SQ_W+1)'(dv_sh - {2'b00, r_root}) : dv_sh[SQ_W:0];
                r_num  <= {r_num[NUM_W-2:0], dv_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            OP_DROW_LD: begin
                r_dcol <= unit_dir(r_num, r_negx);
                r_num  <= (NUM_W'(r_ay) << DIR_SHIFT) + NUM_W'(r_root >> 1);
                r_drem <= '0;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end
            OP_WALK_LD: begin
                r_drow <= unit_dir(r_num, r_negy);
                r_cnt  <= CNT_W'(WALK_LIMIT - 1);
            end
            OP_STEP: begin
                if (xstep) begin
                    r_p <= r_p + (P_W'(r_ay) << FRAC_BITS);
                end else begin
                    r_q <= r_q + (P_W'(r_ax) << FRAC_BITS);
                end
                r_cx <= step_cx;
                r_cy <= step_cy;
            end
            OP_TEST: begin
                r_vis <= o_stat.hit;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.op == OP_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // wall map
    logic          in_range, mem_we, mem_wdata, mem_rdata;
    logic [AW-1:0] mem_addr;
    assign in_range = (int'(in_col) < MAP_SIZE) && (int'(in_row) < MAP_SIZE);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = {step_cy[CW-1:0], step_cx[CW-1:0]};
        if (i_cmd.op == OP_CLEAR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr;
        end else if (i_cmd.map_we) begin
            mem_we    = in_range;
            mem_wdata = in_wall;
            mem_addr  = {CW'(in_row), CW'(in_col)};
        end
    end

    glos_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // status
    logic offmap;
    assign offmap = r_cx[CX_W-1] || r_cy[CX_W-1] || (r_cx >= MAP_S) || (r_cy >= MAP_S);

    assign o_stat.clr_last  = &r_clr;
    assign o_stat.same_cell = (mc == pc) && (mr == pr);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.hit       = (r_cx == CX_W'(r_pc)) && (r_cy == CX_W'(r_pr));
    assign o_stat.blocked   = offmap || mem_rdata;

    // result register
    logic                    r_o_vis, r_o_upd;
    logic signed [DIR_W-1:0] r_o_dcol, r_o_drow;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_vis  <= r_vis;
            r_o_upd  <= r_vis && (r_atk || r_fail || !r_started);
            r_o_dcol <= r_dcol;
            r_o_drow <= r_drow;
        end
    end

    assign o_tdata = {6'b0, r_o_drow, r_o_dcol, r_o_upd, r_o_vis};

    `GLOS_ASSERT_SAME(a_same_cell_walk, i_clk, i_rst_n, i_cmd.op == OP_STEP, !r_same)
    `GLOS_ASSERT_NEXT(a_dir_sat, i_clk, i_rst_n, i_cmd.op == OP_WALK_LD,
                      r_drow <= DIR_ONE && r_drow >= -DIR_ONE)
endmodule

// ===== design/glos_ctrl.sv =====
// ----------------------------------------------------------------------------
// glos_ctrl
// Controller: sequences clear sweep, setup, root, divisions and cell walk,
// and owns both handshakes.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_dda_unit_assert.svh"

module glos_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output glos_pkg::t_dp_cmd  o_cmd,
    input  glos_pkg::t_dp_stat i_stat
);
    import glos_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:    if (i_in_valid && i_in_cmd == CMD_QUERY) n_state = ST_PREP;
            ST_PREP:    n_state = i_stat.same_cell ? ST_DONE : ST_MUL;
            ST_MUL:     n_state = ST_SUM;
            ST_SUM:     n_state = ST_SQRT;
            ST_SQRT:    if (i_stat.cnt_zero) n_state = ST_DCOL_LD;
            ST_DCOL_LD: n_state = ST_DCOL;
            ST_DCOL:    if (i_stat.cnt_zero) n_state = ST_DROW_LD;
            ST_DROW_LD: n_state = ST_DROW;
            ST_DROW:    if (i_stat.cnt_zero) n_state = ST_WALK_LD;
            ST_WALK_LD: n_state = ST_STEP;
            ST_STEP:    n_state = ST_TEST;
            ST_TEST: begin
                if (i_stat.hit || i_stat.blocked || i_stat.cnt_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_DONE:    if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '{op: OP_NONE, accept: 1'b0, map_we: 1'b0, out_load: 1'b0};
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_CLEAR:   o_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.accept  = i_in_valid;
                o_cmd.map_we  = i_in_valid && (i_in_cmd == CMD_WRITE);
            end
            ST_PREP:    o_cmd.op = OP_PREP;
            ST_MUL:     o_cmd.op = OP_MUL;
            ST_SUM:     o_cmd.op = OP_SUM;
            ST_SQRT:    o_cmd.op = OP_SQRT;
            ST_DCOL_LD: o_cmd.op = OP_DCOL_LD;
            ST_DCOL:    o_cmd.op = OP_DIV;
            ST_DROW_LD: o_cmd.op = OP_DROW_LD;
            ST_DROW:    o_cmd.op = OP_DIV;
            ST_WALK_LD: o_cmd.op = OP_WALK_LD;
            ST_STEP:    o_cmd.op = OP_STEP;
            ST_TEST:    o_cmd.op = OP_TEST;
            ST_DONE:    o_cmd.out_load = !r_out_valid || i_out_ready;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    // hold the result until taken; a new load may replace one leaving now
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    `GLOS_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n,
                      o_cmd.accept && i_in_cmd == CMD_QUERY, r_state == ST_PREP)
    `GLOS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, o_cmd.out_load,
                      !r_out_valid || i_out_ready)
    `GLOS_ASSERT_NEXT(a_clear_holds, i_clk, i_rst_n,
                      r_state == ST_CLEAR && !i_stat.clr_last, r_state == ST_CLEAR)
endmodule

// ===== design/grid_line_of_sight_dda_unit.sv =====
// Map write: no result. Query: setup, square root, two serial divisions, then per
// walked cell a map RAM read and then a test, up to 4*MAP_SIZE+4 cells; a query
// whose two positions lie in the same cell skips the root, divisions and walk.
// The result register lets the next item enter while a result waits. After reset
// a clearing pass writes all 2**(2*clog2(MAP_SIZE)) map entries.
// ----------------------------------------------------------------------------
// grid_line_of_sight_dda_unit
// Wall map with DDA line-of-sight queries and unit direction output.
// ----------------------------------------------------------------------------
module grid_line_of_sight_dda_unit #(
    parameter int MAP_SIZE  = glos_pkg::MAP_SIZE_DEF,
    parameter int FRAC_BITS = glos_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // cell_col[5:0] cell_row[11:6] cell_wall[12] mon_col[26:13] mon_row[40:27]
    // player_col[54:41] player_row[68:55] attack_mode[69] player_failed[70]
    // mon_started[71]
    input  logic [glos_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // command[0]
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // visible[0] update_direction[1] dir_col[17:2] dir_row[33:18] zeros[39:34]
    output logic [glos_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import glos_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    glos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_cmd    (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    glos_dp #(
        .MAP_SIZE  (MAP_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_tdata (i_s_axis_tdata),
        .o_tdata (o_m_axis_tdata)
    );
endmodule

// ===== bench/tb_grid_line_of_sight_dda_unit.sv =====
// ----------------------------------------------------------------------------
// Line-of-sight unit bench
// Loads wall cells and runs sight queries through the stream ports: directed
// corners and special cases, random walks near and far, output back-pressure
// and pauses. Every result is checked against an in-bench DDA walker.
// ----------------------------------------------------------------------------
module tb_grid_line_of_sight_dda_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import glos_pkg::*;

    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  MAP_N       = MAP_SIZE_DEF;
    localparam int  FB          = FRAC_BITS_DEF;
    localparam int  WALK_MAX    = 4 * MAP_N + 4;
    localparam int  SETTLE      = 800;

    typedef struct {
        logic             cmd;
        logic [5:0]       cell_col;
        logic [5:0]       cell_row;
        logic             cell_wall;
        logic [POS_W-1:0] mon_col;
        logic [POS_W-1:0] mon_row;
        logic [POS_W-1:0] pl_col;
        logic [POS_W-1:0] pl_row;
        logic             attack;
        logic             failed;
        logic             started;
    } t_sight_req;

    typedef struct {
        logic             visible;
        logic             upd_dir;
        logic [DIR_W-1:0] dir_col;
        logic [DIR_W-1:0] dir_row;
    } t_sight_res;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    bit         wall_copy [MAP_N][MAP_N];
    t_sight_res pending_sight[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         idle_en = 1'b1;
    bit         hold_off = 1'b0;

    grid_line_of_sight_dda_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("grid_line_of_sight_dda_unit test failed");
            $finish;
        end
    end

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [DIR_W-1:0] unit_comp(input longint d, input longint len);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        if (len == 0) return '0;
        q = ((mag << 22) + len / 2) / len;
        if (q > DIR_ONE) q = DIR_ONE;
        if (d < 0) q = -q;
        return q[DIR_W-1:0];
    endfunction

    function automatic bit cell_blocked(input longint c, input longint r);
        if (c < 0 || r < 0 || c >= MAP_N || r >= MAP_N) return 1'b1;
        return wall_copy[r][c];
    endfunction

    // DDA walk from the observer toward the target; updates the map on writes
    function automatic bit trace_sight(input t_sight_req it, output t_sight_res r);
        longint mc, mr, pc, pr, dx, dy, ax, ay, tx, ty, cx, cy, sx, sy, len;
        longint one;
        bit     vis;
        one = longint'(1) << FB;
        r = '{default: '0};
        if (it.cmd == CMD_WRITE) begin
            wall_copy[it.cell_row][it.cell_col] = it.cell_wall;
            return 1'b0;
        end
        mc = it.mon_col >> FB;
        mr = it.mon_row >> FB;
        pc = it.pl_col >> FB;
        pr = it.pl_row >> FB;
        vis = 1'b0;
        if (mc == pc && mr == pr) begin
            vis = 1'b1;
        end else begin
            dx = longint'(it.pl_col) - (mc << FB);
            dy = longint'(it.pl_row) - (mr << FB);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            len = isqrt((ax * ax + ay * ay) << 16);
            r.dir_col = unit_comp(dx, len);
            r.dir_row = unit_comp(dy, len);
            sx = (dx < 0) ? -1 : 1;
            sy = (dy < 0) ? -1 : 1;
            tx = (dx < 0) ? (it.mon_col & (one - 1)) : one - (it.mon_col & (one - 1));
            ty = (dy < 0) ? (it.mon_row & (one - 1)) : one - (it.mon_row & (one - 1));
            cx = mc;
            cy = mr;
            for (int i = 0; i < WALK_MAX; i++) begin
                if (tx * ay < ty * ax) begin
                    tx += one;
                    cx += sx;
                end else begin
                    ty += one;
                    cy += sy;
                end
                if (cx == pc && cy == pr) begin
                    vis = 1'b1;
                    break;
                end
                if (cell_blocked(cx, cy)) break;
            end
        end
        r.visible = vis;
        r.upd_dir = vis && (it.attack || it.failed || !it.started);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [DIR_W-1:0] got,
                                   input logic [DIR_W-1:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // result check: ports are stable at the falling edge before the transaction
    always @(negedge i_clk) begin
        t_sight_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_sight.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata[17:2], '0);
            end else begin
                want = pending_sight.pop_front();
                if (o_m_axis_tdata[0] !== want.visible)
                    report_mismatch("visible", DIR_W'(o_m_axis_tdata[0]),
                                    DIR_W'(want.visible));
                if (o_m_axis_tdata[1] !== want.upd_dir)
                    report_mismatch("update_direction", DIR_W'(o_m_axis_tdata[1]),
                                    DIR_W'(want.upd_dir));
                if (o_m_axis_tdata[17:2] !== want.dir_col)
                    report_mismatch("dir_col", o_m_axis_tdata[17:2], want.dir_col);
                if (o_m_axis_tdata[33:18] !== want.dir_row)
                    report_mismatch("dir_row", o_m_axis_tdata[33:18], want.dir_row);
                if (o_m_axis_tdata[39:34] !== '0)
                    report_mismatch("pad bits", DIR_W'(o_m_axis_tdata[39:34]), '0);
            end
        end
    end

    task automatic send_item(input t_sight_req it);
        t_sight_res r;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.cmd;
        i_s_axis_tdata  <= {it.started, it.failed, it.attack, it.pl_row, it.pl_col,
                            it.mon_row, it.mon_col, it.cell_wall, it.cell_row,
                            it.cell_col};
        do @(negedge i_clk); while (!o_s_axis_tready);
        if (trace_sight(it, r)) pending_sight.push_back(r);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_sight.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_sight_req wall_item(input int c, input int r, input bit w);
        t_sight_req it;
        it = '{default: '0};
        it.cmd = CMD_WRITE;
        it.cell_col = 6'(c);
        it.cell_row = 6'(r);
        it.cell_wall = w;
        it.mon_col = POS_W'($urandom);
        it.pl_row = POS_W'($urandom);
        return it;
    endfunction

    function automatic t_sight_req query_item(input int mc, input int mr,
                                              input int pc, input int pr);
        t_sight_req it;
        it = '{default: '0};
        it.cmd = CMD_QUERY;
        it.mon_col = POS_W'(mc);
        it.mon_row = POS_W'(mr);
        it.pl_col = POS_W'(pc);
        it.pl_row = POS_W'(pr);
        it.attack = 1'($urandom_range(0, 1));
        it.failed = 1'($urandom_range(0, 1));
        it.started = 1'($urandom_range(0, 1));
        it.cell_col = 6'($urandom);
        it.cell_wall = 1'($urandom);
        return it;
    endfunction

    function automatic int near_pos(input int p, input int span);
        int v;
        v = p + $urandom_range(0, 2 * span * 256) - span * 256;
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        return v;
    endfunction

    function automatic t_sight_req random_item();
        int mc, mr;
        if ($urandom_range(0, 2) == 0)
            return wall_item($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 3) == 0);
        mc = $urandom_range(0, 16383);
        mr = $urandom_range(0, 16383);
        if ($urandom_range(0, 3) == 0)
            return query_item(mc, mr, $urandom_range(0, 16383), $urandom_range(0, 16383));
        return query_item(mc, mr, near_pos(mc, 6), near_pos(mr, 6));
    endfunction

    task automatic test_directed();
        t_sight_req it;
        // same cell, with every flag combination
        for (int f = 0; f < 8; f++) begin
            it = query_item(16'h0510, 16'h0720, 16'h05FF, 16'h0701);
            {it.attack, it.failed, it.started} = f[2:0];
            send_item(it);
        end
        // opposite map corners on an open map
        send_item(query_item(0, 0, 16383, 16383));
        send_item(query_item(16383, 16383, 0, 0));
        send_item(query_item(16383, 0, 0, 16383));
        // walls at the extremes, then blocked and missed paths
        send_item(wall_item(0, 0, 1'b1));
        send_item(wall_item(63, 63, 1'b1));
        send_item(wall_item(10, 5, 1'b1));
        send_item(query_item(16'h0580, 16'h0580, 16'h0F80, 16'h0580));
        send_item(query_item(16'h0280, 16'h0380, 16'h0080, 16'h0080));
        send_item(query_item(16'h3E80, 16'h3E80, 16'h3FFF, 16'h3FFF));
        send_item(query_item(16'h0380, 16'h0580, 16'h0480, 16'h0780));
        // reopen a wall and see through it
        send_item(wall_item(10, 5, 1'b0));
        send_item(query_item(16'h0580, 16'h0580, 16'h0F80, 16'h0580));
        send_item(query_item(16'h2000, 16'h2000, 16'h2000, 16'h3FFF));
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        test_random(20);
        wait_drained();
    endtask

    task automatic test_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(600);
        test_backpressure();
        test_pause();
        idle_en = 1'b0;
        test_random(300);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_sight.size() == 0) begin
            $display("grid_line_of_sight_dda_unit test passed");
        end else begin
            $display("grid_line_of_sight_dda_unit test failed");
        end
        $finish;
    end
endmodule
